// ===== rtl/core/cbp_pkg.sv =====
`timescale 1ns / 1ps
package cbp_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int POS_W          = 32;
    localparam int CFG_W          = 23;
    localparam int NEAR_W         = 17;
    localparam int RAD_W          = 23;
    localparam int PIX_W          = 12;
    localparam int MAG_W          = 24;
    localparam int SQ_W           = 48;

    localparam logic [CFG_W-1:0]  RST_UNIT_RADIUS = 23'd19661;
    localparam logic [CFG_W-1:0]  RST_HALF_SIZE   = 23'd26214;
    localparam logic [CFG_W-1:0]  RST_SHOVE       = 23'd5243;
    localparam logic [NEAR_W-1:0] RST_NEAR_ZERO   = 17'd66;

    typedef enum logic [1:0] {
        CONTACT_NONE  = 2'd0,
        CONTACT_SHOVE = 2'd1,
        CONTACT_EDGE  = 2'd2,
        CONTACT_TOUCH = 2'd3
    } contact_t;

    typedef enum logic [1:0] {
        CFG_UNIT_RADIUS = 2'd0,
        CFG_HALF_SIZE   = 2'd1,
        CFG_SHOVE       = 2'd2,
        CFG_NEAR_ZERO   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [RAD_W-1:0] size;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0]  shove;
        logic [NEAR_W-1:0] near_zero;
    } cfg_back_t;

    typedef struct packed {
        logic [POS_W-1:0] ux;
        logic [POS_W-1:0] uy;
        contact_t         contact;
    } res_t;

endpackage

// ===== rtl/core/cbp_fifo.sv =====
`timescale 1ns / 1ps
module cbp_fifo #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          empty
);

    logic [DW-1:0] mem [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/core/cbp_front.sv =====
`timescale 1ns / 1ps
module cbp_front import cbp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             mode,
    input  logic [POS_W-1:0] pos_x,
    input  logic [POS_W-1:0] pos_y,
    input  logic [PIX_W-1:0] radius_pixels,
    input  logic             radius_given,
    output item_t            item,
    output cfg_back_t        cfg_out
);

    logic [CFG_W-1:0]  unit_radius_reg;
    logic [CFG_W-1:0]  half_size_reg;
    logic [CFG_W-1:0]  shove_reg;
    logic [NEAR_W-1:0] near_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_radius_reg <= RST_UNIT_RADIUS;
            half_size_reg   <= RST_HALF_SIZE;
            shove_reg       <= RST_SHOVE;
            near_zero_reg   <= RST_NEAR_ZERO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_UNIT_RADIUS: unit_radius_reg <= cfg_data;
                CFG_HALF_SIZE:   half_size_reg   <= cfg_data;
                CFG_SHOVE:       shove_reg       <= cfg_data;
                CFG_NEAR_ZERO:   near_zero_reg   <= cfg_data[NEAR_W-1:0];
                default:         shove_reg       <= shove_reg;
            endcase
        end
    end

    // A pixel radius becomes Q16.16 tiles by a shift of ten.
    always_comb
    begin
        item.mode = mode;
        item.px   = pos_x;
        item.py   = pos_y;
        if (radius_given)
        begin
            item.size = {1'b0, radius_pixels, 10'b0};
        end
        else
        begin
            item.size = mode ? half_size_reg : unit_radius_reg;
        end
        cfg_out.shove     = shove_reg;
        cfg_out.near_zero = near_zero_reg;
    end

endmodule

// ===== rtl/core/cbp_back.sv =====
`timescale 1ns / 1ps
module cbp_back import cbp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     item,
    input  logic      item_valid,
    output logic      item_pop,
    input  cfg_back_t cfg,
    input  logic      res_full,
    output logic      res_push,
    output res_t      res
);

    localparam int EW = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 3;

    localparam logic signed [EW-1:0] C_MAX =
        {{(EW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] C_MIN =
        {{(EW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [EW-1:0] O_MAX =
        {{(EW-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [EW-1:0] O_MIN =
        {{(EW-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLASS = 10'b0000000010,
        ST_SQA   = 10'b0000000100,
        ST_SQB   = 10'b0000001000,
        ST_CHK   = 10'b0000010000,
        ST_ROOT  = 10'b0000100000,
        ST_LEN   = 10'b0001000000,
        ST_MUL   = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t                   state_reg;
    logic [COORD_BITS-1:0]    ux_reg;
    logic [COORD_BITS-1:0]    uy_reg;
    logic [RAD_W-1:0]         r_reg;
    logic signed [EW-1:0]     px_reg;
    logic signed [EW-1:0]     py_reg;
    logic [RAD_W-1:0]         h_reg;
    logic signed [MAG_W-1:0]  a_reg;
    logic signed [MAG_W-1:0]  b_reg;
    logic                     inside_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          rr_reg;
    logic [26:0]              rem_reg;
    logic [MAG_W-1:0]         root_reg;
    logic [SQ_W-1:0]          num_reg;
    logic [MAG_W-1:0]         drem_reg;
    logic [MAG_W-1:0]         q_reg;
    logic [RAD_W-1:0]         len_reg;
    logic [4:0]               cnt_reg;
    logic                     second_reg;
    logic signed [EW-1:0]     nx_reg;
    logic signed [EW-1:0]     ny_reg;
    contact_t                 contact_reg;

    logic signed [EW-1:0]     ux_e;
    logic signed [EW-1:0]     uy_e;
    logic signed [EW-1:0]     h_e;
    logic signed [EW-1:0]     r_e;
    logic signed [EW-1:0]     lo_x;
    logic signed [EW-1:0]     hi_x;
    logic signed [EW-1:0]     lo_y;
    logic signed [EW-1:0]     hi_y;
    logic signed [EW-1:0]     cx;
    logic signed [EW-1:0]     cy;
    logic signed [EW-1:0]     ex;
    logic signed [EW-1:0]     ey;
    logic signed [EW-1:0]     abs_ex;
    logic signed [EW-1:0]     abs_ey;
    logic                     inside_c;
    logic                     near_c;
    logic signed [SQ_W-1:0]   sq_a;
    logic signed [SQ_W-1:0]   sq_b;
    logic [SQ_W-1:0]          rr_c;
    logic [26:0]              rem2;
    logic [26:0]              trial;
    logic signed [MAG_W-1:0]  sel;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W-1:0]          num_c;
    logic [MAG_W:0]           drem2;
    logic                     qbit;
    logic [MAG_W-1:0]         q_fin;
    logic signed [EW-1:0]     q_s;
    logic signed [EW-1:0]     sat_x;
    logic signed [EW-1:0]     sat_y;
    logic signed [EW-1:0]     out_x;
    logic signed [EW-1:0]     out_y;

    function automatic logic signed [EW-1:0] sat_to(
        input logic signed [EW-1:0] v,
        input logic signed [EW-1:0] vmax,
        input logic signed [EW-1:0] vmin
    );
        logic signed [EW-1:0] o;
        o = v;
        if (v > vmax)
        begin
            o = vmax;
        end
        else if (v < vmin)
        begin
            o = vmin;
        end
        return o;
    endfunction

    always_comb
    begin
        ux_e   = {{(EW-COORD_BITS){ux_reg[COORD_BITS-1]}}, ux_reg};
        uy_e   = {{(EW-COORD_BITS){uy_reg[COORD_BITS-1]}}, uy_reg};
        h_e    = {{(EW-RAD_W){1'b0}}, h_reg};
        r_e    = {{(EW-RAD_W){1'b0}}, r_reg};
        lo_x   = px_reg - h_e;
        hi_x   = px_reg + h_e;
        lo_y   = py_reg - h_e;
        hi_y   = py_reg + h_e;
        inside_c = (ux_e > lo_x) && (ux_e < hi_x) && (uy_e > lo_y) && (uy_e < hi_y);
        cx     = (ux_e < lo_x) ? lo_x : ((ux_e > hi_x) ? hi_x : ux_e);
        cy     = (uy_e < lo_y) ? lo_y : ((uy_e > hi_y) ? hi_y : uy_e);
        ex     = ux_e - cx;
        ey     = uy_e - cy;
        abs_ex = ex[EW-1] ? -ex : ex;
        abs_ey = ey[EW-1] ? -ey : ey;
        near_c = (abs_ex < r_e) && (abs_ey < r_e);

        sq_a   = a_reg * a_reg;
        sq_b   = b_reg * b_reg;
        rr_c   = {{(SQ_W-RAD_W){1'b0}}, r_reg} * {{(SQ_W-RAD_W){1'b0}}, r_reg};

        rem2   = {rem_reg[24:0], num_reg[SQ_W-1:SQ_W-2]};
        trial  = {1'b0, root_reg, 2'b01};

        sel    = second_reg ? b_reg : a_reg;
        mag    = sel[MAG_W-1] ? MAG_W'(-sel) : MAG_W'(sel);
        num_c  = {{(SQ_W-MAG_W){1'b0}}, mag} * {{(SQ_W-RAD_W){1'b0}}, len_reg}
                 + {{(SQ_W-MAG_W+1){1'b0}}, root_reg[MAG_W-1:1]};

        drem2  = {drem_reg, num_reg[MAG_W-1]};
        qbit   = (drem2 >= {1'b0, root_reg});
        q_fin  = {q_reg[MAG_W-2:0], qbit};
        q_s    = {{(EW-MAG_W){1'b0}}, q_fin};

        sat_x  = sat_to(nx_reg, C_MAX, C_MIN);
        sat_y  = sat_to(ny_reg, C_MAX, C_MIN);
        out_x  = sat_to(sat_x, O_MAX, O_MIN);
        out_y  = sat_to(sat_y, O_MAX, O_MIN);

        res.ux      = out_x[POS_W-1:0];
        res.uy      = out_y[POS_W-1:0];
        res.contact = contact_reg;
        res_push    = (state_reg == ST_DONE);
        item_pop    = (state_reg == ST_IDLE) && item_valid && !res_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ux_reg    <= '0;
            uy_reg    <= '0;
            r_reg     <= RST_UNIT_RADIUS;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_pop)
                    begin
                        if (!item.mode)
                        begin
                            r_reg     <= item.size;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_CLASS;
                        end
                    end
                end
                ST_CLASS:
                begin
                    state_reg <= (inside_c || near_c) ? ST_SQA : ST_DONE;
                end
                ST_SQA:  state_reg <= ST_SQB;
                ST_SQB:  state_reg <= ST_CHK;
                ST_CHK:
                begin
                    if (!inside_reg && ((sq_reg >= rr_reg) || (sq_reg == '0)))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (cnt_reg == 5'd23)
                    begin
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN:
                begin
                    if (inside_reg && ((root_reg < {7'b0, cfg.near_zero}) || (root_reg == '0)))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:  state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (cnt_reg == 5'd23)
                    begin
                        state_reg <= second_reg ? ST_DONE : ST_MUL;
                    end
                end
                ST_DONE:
                begin
                    ux_reg    <= sat_x[COORD_BITS-1:0];
                    uy_reg    <= sat_y[COORD_BITS-1:0];
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                px_reg      <= {{(EW-POS_W){item.px[POS_W-1]}}, item.px};
                py_reg      <= {{(EW-POS_W){item.py[POS_W-1]}}, item.py};
                nx_reg      <= {{(EW-POS_W){item.px[POS_W-1]}}, item.px};
                ny_reg      <= {{(EW-POS_W){item.py[POS_W-1]}}, item.py};
                h_reg       <= item.size;
                contact_reg <= CONTACT_NONE;
            end
            ST_CLASS:
            begin
                nx_reg     <= ux_e;
                ny_reg     <= uy_e;
                inside_reg <= inside_c;
                a_reg      <= inside_c ? MAG_W'(ux_e - px_reg) : MAG_W'(ex);
                b_reg      <= inside_c ? MAG_W'(uy_e - py_reg) : MAG_W'(ey);
            end
            ST_SQA:
            begin
                sq_reg <= sq_a;
                rr_reg <= rr_c;
            end
            ST_SQB:
            begin
                sq_reg <= sq_reg + sq_b;
            end
            ST_CHK:
            begin
                if (!inside_reg && (sq_reg < rr_reg) && (sq_reg == '0))
                begin
                    nx_reg      <= nx_reg + r_e;
                    contact_reg <= CONTACT_TOUCH;
                end
                rem_reg  <= '0;
                root_reg <= '0;
                num_reg  <= sq_reg;
                cnt_reg  <= '0;
            end
            ST_ROOT:
            begin
                if (rem2 >= trial)
                begin
                    rem_reg  <= rem2 - trial;
                    root_reg <= {root_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem2;
                    root_reg <= {root_reg[MAG_W-2:0], 1'b0};
                end
                num_reg <= {num_reg[SQ_W-3:0], 2'b00};
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_LEN:
            begin
                second_reg <= 1'b0;
                if (inside_reg)
                begin
                    contact_reg <= CONTACT_SHOVE;
                    len_reg     <= cfg.shove;
                    if ((root_reg < {7'b0, cfg.near_zero}) || (root_reg == '0))
                    begin
                        nx_reg <= nx_reg + {{(EW-CFG_W){1'b0}}, cfg.shove};
                    end
                end
                else
                begin
                    contact_reg <= CONTACT_EDGE;
                    len_reg     <= r_reg - root_reg[RAD_W-1:0];
                end
            end
            ST_MUL:
            begin
                num_reg  <= num_c;
                drem_reg <= num_c[SQ_W-1:MAG_W];
                q_reg    <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV:
            begin
                drem_reg <= qbit ? MAG_W'(drem2 - {1'b0, root_reg}) : drem2[MAG_W-1:0];
                q_reg    <= q_fin;
                num_reg  <= {num_reg[SQ_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    second_reg <= 1'b1;
                    if (second_reg)
                    begin
                        ny_reg <= sel[MAG_W-1] ? ny_reg - q_s : ny_reg + q_s;
                    end
                    else
                    begin
                        nx_reg <= sel[MAG_W-1] ? nx_reg - q_s : nx_reg + q_s;
                    end
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

// ===== rtl/core/circle_box_pushout.sv =====
`timescale 1ns / 1ps
// A load beat passes from the idle state to the done state, which writes its result.
// An obstacle beat with no contact ends at the classify or distance check state; an edge
// or shove push runs the 24-step square root and, unless near zero, two 24-step divisions.
// Beats are worked one at a time; two input and two result beats can wait in the queues.
// Reset clears the unit position to zero and loads the default register values.
module circle_box_pushout import cbp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             push,
    output logic             full,
    input  logic             mode,
    input  logic [POS_W-1:0] pos_x,
    input  logic [POS_W-1:0] pos_y,
    input  logic [PIX_W-1:0] radius_pixels,
    input  logic             radius_given,
    output logic             empty,
    input  logic             pop,
    output logic [POS_W-1:0] unit_x,
    output logic [POS_W-1:0] unit_y,
    output logic [1:0]       contact
);

    item_t     item_in;
    item_t     item_q;
    cfg_back_t cfg_back;
    logic      q_empty;
    logic      q_pop;
    logic      res_full;
    logic      res_push;
    res_t      res_in;
    res_t      res_out;

    cbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .radius_pixels (radius_pixels),
        .radius_given  (radius_given),
        .item          (item_in),
        .cfg_out       (cfg_back)
    );

    cbp_fifo #(.DW($bits(item_t))) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item_in),
        .full  (full),
        .pop   (q_pop),
        .dout  (item_q),
        .empty (q_empty)
    );

    cbp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_q),
        .item_valid (!q_empty),
        .item_pop   (q_pop),
        .cfg        (cfg_back),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    cbp_fifo #(.DW($bits(res_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign unit_x  = res_out.ux;
    assign unit_y  = res_out.uy;
    assign contact = res_out.contact;

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_item_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("item taken from an empty item queue");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("second item taken while one is still in work");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import cbp_pkg::*;

    typedef struct {
        logic [POS_W-1:0] ux;
        logic [POS_W-1:0] uy;
        contact_t         contact;
    } pos_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             push;
    logic             full;
    logic             mode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] radius_pixels;
    logic             radius_given;
    logic             empty;
    logic             pop;
    logic [POS_W-1:0] unit_x;
    logic [POS_W-1:0] unit_y;
    logic [1:0]       contact;

    pos_result_t       pending_positions[$];
    int                errors;
    int                idle_cycles;
    int                hold_cycles;
    int                pop_stall;
    bit                sender_eager;
    bit                receiver_eager;

    longint            mdl_ux;
    longint            mdl_uy;
    longint unsigned   mdl_radius;
    longint unsigned   reg_unit_radius;
    longint unsigned   reg_half_size;
    longint unsigned   reg_shove;
    longint unsigned   reg_near_zero;

    circle_box_pushout uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .radius_pixels(radius_pixels),
        .radius_given (radius_given),
        .empty        (empty),
        .pop          (pop),
        .unit_x       (unit_x),
        .unit_y       (unit_y),
        .contact      (contact)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint push_component(longint num, longint unsigned len,
                                              longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag * len + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unsigned mag_of(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    task automatic resolve_position(input logic m, input logic [31:0] x_in,
                                    input logic [31:0] y_in, input logic [11:0] rp,
                                    input logic rg);
        longint px;
        longint py;
        longint h;
        longint nx;
        longint ny;
        longint dx;
        longint dy;
        longint cx;
        longint cy;
        longint unsigned d;
        longint unsigned dsq;
        longint unsigned r;
        pos_result_t res;
        contact_t c;
        px = longint'($signed(x_in));
        py = longint'($signed(y_in));
        c = CONTACT_NONE;
        if (m == 1'b0)
        begin
            mdl_ux = px;
            mdl_uy = py;
            mdl_radius = rg ? longint'(rp) * 1024 : reg_unit_radius;
        end
        else
        begin
            h = rg ? longint'(rp) * 1024 : longint'(reg_half_size);
            nx = mdl_ux;
            ny = mdl_uy;
            if (mdl_ux > px - h && mdl_ux < px + h && mdl_uy > py - h && mdl_uy < py + h)
            begin
                dx = mdl_ux - px;
                dy = mdl_uy - py;
                d = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
                if (d < reg_near_zero || d == 0)
                begin
                    nx = mdl_ux + longint'(reg_shove);
                end
                else
                begin
                    nx = mdl_ux + push_component(dx, reg_shove, d);
                    ny = mdl_uy + push_component(dy, reg_shove, d);
                end
                c = CONTACT_SHOVE;
            end
            else
            begin
                cx = (mdl_ux < px - h) ? px - h : ((mdl_ux > px + h) ? px + h : mdl_ux);
                cy = (mdl_uy < py - h) ? py - h : ((mdl_uy > py + h) ? py + h : mdl_uy);
                dx = mdl_ux - cx;
                dy = mdl_uy - cy;
                r = mdl_radius;
                if (mag_of(dx) < r && mag_of(dy) < r)
                begin
                    dsq = longint'(dx * dx) + longint'(dy * dy);
                    if (dsq < r * r)
                    begin
                        if (dsq == 0)
                        begin
                            nx = mdl_ux + longint'(r);
                            c = CONTACT_TOUCH;
                        end
                        else
                        begin
                            d = int_sqrt(dsq);
                            nx = mdl_ux + push_component(dx, r - d, d);
                            ny = mdl_uy + push_component(dy, r - d, d);
                            c = CONTACT_EDGE;
                        end
                    end
                end
            end
            mdl_ux = sat_coord(nx);
            mdl_uy = sat_coord(ny);
        end
        res.ux = mdl_ux[31:0];
        res.uy = mdl_uy[31:0];
        res.contact = c;
        pending_positions.push_back(res);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_beat(input logic m, input logic [31:0] x_in,
                             input logic [31:0] y_in, input logic [11:0] rp,
                             input logic rg);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        mode <= m;
        pos_x <= x_in;
        pos_y <= y_in;
        radius_pixels <= rp;
        radius_given <= rg;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        resolve_position(m, x_in, y_in, rp, rg);
    endtask

    task automatic drain;
        @(negedge clk);
        push <= 1'b0;
        while (pending_positions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_UNIT_RADIUS: reg_unit_radius = value;
            CFG_HALF_SIZE:   reg_half_size = value;
            CFG_SHOVE:       reg_shove = value;
            default:         reg_near_zero = value[NEAR_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] ur, input logic [CFG_W-1:0] hs,
                              input logic [CFG_W-1:0] sh, input logic [CFG_W-1:0] nz);
        drain();
        write_reg(CFG_UNIT_RADIUS, ur);
        write_reg(CFG_HALF_SIZE, hs);
        write_reg(CFG_SHOVE, sh);
        write_reg(CFG_NEAR_ZERO, nz);
    endtask

    task automatic test_directed;
        send_beat(1'b1, 32'd0, 32'd0, 12'd0, 1'b0);
        send_beat(1'b0, 32'd0, 32'd0, 12'd0, 1'b0);
        send_beat(1'b1, 32'd10, 32'd0, 12'd64, 1'b1);
        send_beat(1'b0, 32'h0001_0000, 32'h0001_0000, 12'd20, 1'b1);
        send_beat(1'b1, 32'h0001_8000, 32'h0000_C000, 12'd64, 1'b1);
        send_beat(1'b0, 32'h0002_0000, 32'h0000_0000, 12'd32, 1'b1);
        send_beat(1'b1, 32'h0000_0000, 32'h0000_0000, 12'd64, 1'b1);
        send_beat(1'b0, 32'h0002_4000, 32'h0000_8000, 12'd32, 1'b1);
        send_beat(1'b1, 32'h0000_0000, 32'h0000_0000, 12'd128, 1'b1);
        send_beat(1'b0, 32'h0005_0000, 32'h0000_0000, 12'd0, 1'b1);
        send_beat(1'b1, 32'h0004_0000, 32'h0000_0000, 12'd64, 1'b1);
        send_beat(1'b1, 32'h0009_0000, 32'h0000_0000, 12'd64, 1'b1);
        send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 12'd4095, 1'b1);
        send_beat(1'b1, 32'h7FFF_0000, 32'h8000_1000, 12'd4095, 1'b1);
        send_beat(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 12'd0, 1'b0);
        send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 12'd0, 1'b0);
        send_beat(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 12'd0, 1'b0);
        send_beat(1'b1, 32'h8000_0000 + 32'd26214 + 32'd100, 32'h7FFF_FFFF, 12'd0, 1'b0);
        send_beat(1'b0, 32'hFFFF_0000, 32'hFFFF_0000, 12'd4095, 1'b1);
        send_beat(1'b1, 32'hFFFF_0000, 32'hFFFF_0000, 12'd4095, 1'b1);
        send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hAAA, 1'b1);
        send_beat(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 12'h555, 1'b1);
    endtask

    task automatic random_sequence;
        logic [31:0] bx;
        logic [31:0] by;
        int n;
        int reach;
        if ($urandom_range(0, 7) == 0)
        begin
            send_beat(1'($urandom_range(0, 1)), $urandom, $urandom, 12'($urandom),
                      1'($urandom_range(0, 1)));
            return;
        end
        bx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        by = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        send_beat(1'b0, bx, by, 12'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 96)),
                  $urandom_range(0, 3) != 0);
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            reach = $urandom_range(0, 3) == 0 ? 32'h0002_0000 : 32'h0006_0000;
            send_beat(1'b1, bx + $urandom_range(0, 2 * reach) - reach,
                      by + $urandom_range(0, 2 * reach) - reach,
                      12'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 96)),
                      $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_random(input int beats);
        repeat (beats / 4)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                sender_eager = ~sender_eager;
                receiver_eager = ~receiver_eager;
            end
            random_sequence();
        end
        sender_eager = 1'b0;
        receiver_eager = 1'b0;
    endtask

    task automatic test_backpressure;
        hold_cycles = 400;
        sender_eager = 1'b1;
        repeat (3) random_sequence();
        sender_eager = 1'b0;
    endtask

    task automatic test_sender_pause;
        random_sequence();
        drain();
        random_sequence();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_positions.size() == 0)
            begin
                report("unexpected beat", unit_x, 0);
            end
            else
            begin
                if (unit_x !== pending_positions[0].ux)
                    report("unit_x", $signed(unit_x), $signed(pending_positions[0].ux));
                if (unit_y !== pending_positions[0].uy)
                    report("unit_y", $signed(unit_y), $signed(pending_positions[0].uy));
                if (contact !== pending_positions[0].contact)
                    report("contact", contact, pending_positions[0].contact);
                void'(pending_positions.pop_front());
            end
            pop_stall <= receiver_eager ? 0 : $urandom_range(0, 12);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else if (pop_stall > 0)
        begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= 20000)
        begin
            $display("circle_box_pushout regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_UNIT_RADIUS;
        cfg_data = '0;
        push = 1'b0;
        mode = 1'b0;
        pos_x = '0;
        pos_y = '0;
        radius_pixels = '0;
        radius_given = 1'b0;
        pop = 1'b0;
        errors = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        pop_stall = 0;
        sender_eager = 1'b0;
        receiver_eager = 1'b0;
        reg_unit_radius = RST_UNIT_RADIUS;
        reg_half_size = RST_HALF_SIZE;
        reg_shove = RST_SHOVE;
        reg_near_zero = RST_NEAR_ZERO;
        mdl_ux = 0;
        mdl_uy = 0;
        mdl_radius = RST_UNIT_RADIUS;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random(250);
        set_config(23'd0, 23'd0, 23'd0, 23'h7E0000);
        test_directed();
        test_random(150);
        set_config(23'd4194304, 23'd4194304, 23'd4194304, 23'd65536);
        test_directed();
        test_random(150);
        set_config(23'h7FFFFF, 23'd40000, 23'd70000, 23'h7FFFFF);
        test_random(150);
        set_config(23'd30000, 23'd50000, 23'd9000, 23'd3000);
        test_random(250);
        drain();

        if (errors == 0)
        begin
            $display("circle_box_pushout regression: pass");
        end
        else
        begin
            $display("circle_box_pushout regression: fail");
        end
        $finish;
    end

endmodule
